/* hw/rtl/clse_pkg.sv */
// Shared types and constants of the clock sync latency estimator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package clse_pkg;

  // Sizes of the words at the block boundary.
  localparam int TIME_W = 63;
  localparam int TS_W   = 16;
  localparam int OFF_W  = 64;

  // Timestamps wrap modulo 2^TS_W (65536), so modular differences are plain
  // TS_W-bit subtractions.
  localparam logic [TS_W-1:0] NO_LATENCY = {TS_W{1'b1}};

  localparam logic OP_RECEIVE  = 1'b0;
  localparam logic OP_TRANSMIT = 1'b1;

  // Offset window.
  localparam int WINDOW = 8;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int ACC_W  = OFF_W + CNT_W;

  // Divider: DIV_DIGIT quotient bits per cycle.
  localparam int DIV_DIGIT = 4;
  localparam int DIV_STEPS = (ACC_W + DIV_DIGIT - 1) / DIV_DIGIT;
  localparam int DIV_W     = DIV_STEPS * DIV_DIGIT;
  localparam int DC_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OFFS,
    ST_SUM,
    ST_NEG,
    ST_DIV,
    ST_FIX,
    ST_EMIT
  } clse_state_t;

  typedef struct packed {
    logic              opcode;
    logic [TIME_W-1:0] local_time;
    logic [TS_W-1:0]   rx_timestamp;
    logic [TS_W-1:0]   remote_timestamp;
    logic [TS_W-1:0]   latency_corrector;
    logic [TS_W-1:0]   peer_reported_latency;
    logic [TIME_W-1:0] remote_full_timestamp;
    logic              remote_has_ours;
    logic [TS_W-1:0]   echoed_timestamp;
  } clse_item_t;

  typedef struct packed {
    logic [TS_W-1:0]         latency;
    logic [TS_W-1:0]         round_trip;
    logic                    round_trip_valid;
    logic signed [OFF_W-1:0] mean_clock_offset;
    logic                    offset_valid;
    logic [TS_W-1:0]         peer_latency;
    logic [TS_W-1:0]         tx_timestamp;
    logic [TS_W-1:0]         tx_corrector_latency;
    logic                    tx_have_external;
    logic [TS_W-1:0]         tx_external_timestamp;
  } clse_result_t;

  typedef struct packed {
    logic load;      // capture the input word
    logic exec;      // apply the receive or transmit update
    logic offs;      // push the new offset into the window
    logic sum_step;  // add one window entry to the accumulator
    logic neg;       // take the magnitude and start the divider
    logic div_step;  // one divider iteration
    logic fix;       // restore the sign and store the mean
    logic emit;      // load the output register
  } clse_cmd_t;

  typedef struct packed {
    logic measure;   // the current item yields a new offset
    logic sum_last;  // last window entry is being added
    logic div_last;  // last divider iteration is running
  } clse_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/clse_if.sv */
// Handshake channels of the clock sync latency estimator: request and response.
// Depends on clse_pkg for the field widths.
`default_nettype none

interface clse_req_if;
  import clse_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [TIME_W-1:0] local_time;
  logic [TS_W-1:0]   rx_timestamp;
  logic [TS_W-1:0]   remote_timestamp;
  logic [TS_W-1:0]   latency_corrector;
  logic [TS_W-1:0]   peer_reported_latency;
  logic [TIME_W-1:0] remote_full_timestamp;
  logic              remote_has_ours;
  logic [TS_W-1:0]   echoed_timestamp;

  modport source (
    output valid, opcode, local_time, rx_timestamp, remote_timestamp,
           latency_corrector, peer_reported_latency, remote_full_timestamp,
           remote_has_ours, echoed_timestamp,
    input  ready
  );

  modport sink (
    input  valid, opcode, local_time, rx_timestamp, remote_timestamp,
           latency_corrector, peer_reported_latency, remote_full_timestamp,
           remote_has_ours, echoed_timestamp,
    output ready
  );
endinterface

interface clse_rsp_if;
  import clse_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [TS_W-1:0]         latency;
  logic [TS_W-1:0]         round_trip;
  logic                    round_trip_valid;
  logic signed [OFF_W-1:0] mean_clock_offset;
  logic                    offset_valid;
  logic [TS_W-1:0]         peer_latency;
  logic [TS_W-1:0]         tx_timestamp;
  logic [TS_W-1:0]         tx_corrector_latency;
  logic                    tx_have_external;
  logic [TS_W-1:0]         tx_external_timestamp;

  modport source (
    output valid, latency, round_trip, round_trip_valid, mean_clock_offset,
           offset_valid, peer_latency, tx_timestamp, tx_corrector_latency,
           tx_have_external, tx_external_timestamp,
    input  ready
  );

  modport sink (
    input  valid, latency, round_trip, round_trip_valid, mean_clock_offset,
           offset_valid, peer_latency, tx_timestamp, tx_corrector_latency,
           tx_have_external, tx_external_timestamp,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/clock_sync_latency_estimator_top.sv */
// A transmit word or a receive word that measures nothing goes from acceptance through the
// update state to the emit state; a measuring receive word in between pushes its offset,
// adds the N = 1..8 window entries one at a time, takes the magnitude, runs the iterative
// divide and restores the sign. One word at a time: the next word is taken in the cycle
// after the result is loaded, and loading waits while the output register holds an untaken result.
// Reset: synchronous, active high; all sync state returns to its reset values at once.
`default_nettype none

module clock_sync_latency_estimator_top (
  input  wire logic clk,
  input  wire logic rst,
  clse_req_if.sink  req,
  clse_rsp_if.source rsp
);
  import clse_pkg::*;

  // The controller walks each accepted word through the datapath:
  // capture, update of the sync state, and for a receive word that yields
  // a new clock offset the window push, the serial window sum, the
  // magnitude step, the iterative divide by the fill count and the sign
  // fix. The result then waits in the output register, which frees the
  // input side as soon as the result is loaded.

  clse_cmd_t    cmd;
  clse_sts_t    sts;
  clse_item_t   item;
  clse_result_t result;

  assign item.opcode                = req.opcode;
  assign item.local_time            = req.local_time;
  assign item.rx_timestamp          = req.rx_timestamp;
  assign item.remote_timestamp      = req.remote_timestamp;
  assign item.latency_corrector     = req.latency_corrector;
  assign item.peer_reported_latency = req.peer_reported_latency;
  assign item.remote_full_timestamp = req.remote_full_timestamp;
  assign item.remote_has_ours       = req.remote_has_ours;
  assign item.echoed_timestamp      = req.echoed_timestamp;

  clse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  clse_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .item_in (item),
    .result  (result)
  );

  // Result fields go straight out of the output register.
  assign rsp.latency               = result.latency;
  assign rsp.round_trip            = result.round_trip;
  assign rsp.round_trip_valid      = result.round_trip_valid;
  assign rsp.mean_clock_offset     = result.mean_clock_offset;
  assign rsp.offset_valid          = result.offset_valid;
  assign rsp.peer_latency          = result.peer_latency;
  assign rsp.tx_timestamp          = result.tx_timestamp;
  assign rsp.tx_corrector_latency  = result.tx_corrector_latency;
  assign rsp.tx_have_external      = result.tx_have_external;
  assign rsp.tx_external_timestamp = result.tx_external_timestamp;

  // A word is worked on alone: right after acceptance the input side closes.
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("input accepted again while a word is in work");

  // A mean is only ever formed after a round trip was measured.
  a_offset_needs_rt: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.offset_valid |-> rsp.round_trip_valid)
    else $error("offset reported without a round trip");

  // Without an echoed peer timestamp the transmit fields carry their idle values.
  a_tx_idle: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.tx_have_external |->
      rsp.tx_external_timestamp == '0 && rsp.tx_corrector_latency == NO_LATENCY)
    else $error("transmit fields set without an echoed timestamp");

endmodule

`default_nettype wire

/* hw/rtl/clse_div.sv */
// Iterative unsigned divider, DIV_DIGIT quotient bits per cycle while step is high, small divisor.
// Depends on clse_pkg for widths.
`default_nettype none

module clse_div (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic                  step,
  input  wire logic [clse_pkg::DIV_W-1:0] dividend,
  input  wire logic [clse_pkg::CNT_W-1:0] divisor,
  output logic [clse_pkg::DIV_W-1:0]      quotient,
  output logic                            last
);
  import clse_pkg::*;

  logic [DIV_W-1:0] dq;
  logic [DIV_W-1:0] dq_next;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] rem_next;
  logic [DC_W-1:0]  cnt;
  logic [CNT_W:0]   trial;
  logic             qbit;

  // The remainder stays below the divisor, so each trial subtract is narrow.
  always_comb begin
    rem_next = rem;
    dq_next  = dq;
    trial    = '0;
    qbit     = 1'b0;
    for (int k = 0; k < DIV_DIGIT; k++) begin
      trial = {rem_next, dq_next[DIV_W-1]};
      qbit  = (trial >= {1'b0, divisor});
      if (qbit) begin
        rem_next = CNT_W'(trial - {1'b0, divisor});
      end else begin
        rem_next = trial[CNT_W-1:0];
      end
      dq_next = {dq_next[DIV_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + DC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
    end else if (step) begin
      dq  <= dq_next;
      rem <= rem_next;
    end
  end

  assign quotient = dq;
  assign last     = (cnt == DC_W'(DIV_STEPS - 1));

endmodule

`default_nettype wire

/* hw/rtl/clse_dp.sv */
// Datapath of the clock sync latency estimator: sync state, offset window,
// window sum, mean and the output register. Depends on clse_pkg and clse_div.
`default_nettype none

module clse_dp (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire clse_pkg::clse_cmd_t     cmd,
  output clse_pkg::clse_sts_t          sts,
  input  wire clse_pkg::clse_item_t    item_in,
  output clse_pkg::clse_result_t       result
);
  import clse_pkg::*;

  clse_item_t item;

  // Architectural state.
  logic [TS_W-1:0]  latency_value;
  logic [TS_W-1:0]  round_trip_value;
  logic             round_trip_seen;
  logic [TS_W-1:0]  peer_latency_value;
  logic [OFF_W-1:0] mean_offset;
  logic             mean_seen;
  logic [TS_W-1:0]  stored_peer_timestamp;
  logic             have_peer_timestamp;
  logic [TS_W-1:0]  corrector_time;
  logic             corrector_pending;
  logic [CNT_W-1:0] offset_count;
  logic [IDX_W-1:0] wr_ptr;
  logic [OFF_W-1:0] offset_window [WINDOW];

  // Working registers.
  logic [OFF_W-1:0] time_diff;
  logic [TS_W-1:0]  tx_corr;
  logic             tx_have;
  logic [TS_W-1:0]  tx_ext;
  logic [IDX_W-1:0] sum_idx;
  logic [ACC_W-1:0] acc;
  logic             sum_neg;

  // Combinational helpers.
  logic             free_slot;
  logic             is_tx;
  logic [TS_W-1:0]  now_ts;
  logic [TS_W-1:0]  rt_new;
  logic [TS_W:0]    lat_diff;
  logic [TS_W:0]    lat_half;
  logic [OFF_W-1:0] new_offset;
  logic [OFF_W-1:0] win_rd;
  logic [ACC_W-1:0] acc_mag;
  logic [DIV_W-1:0] quotient;
  logic             div_last;

  assign free_slot = ~corrector_pending;
  assign is_tx     = (item.opcode == OP_TRANSMIT);
  assign now_ts    = item.local_time[TS_W-1:0];
  assign rt_new    = item.rx_timestamp - item.echoed_timestamp;
  assign lat_diff  = {1'b0, rt_new} - {1'b0, item.latency_corrector};
  // Halve with truncation toward zero.
  assign lat_half  = $signed(lat_diff + {{TS_W{1'b0}}, lat_diff[TS_W]}) >>> 1;
  assign new_offset = time_diff + OFF_W'(latency_value);
  assign win_rd    = offset_window[sum_idx];
  assign acc_mag   = acc[ACC_W-1] ? ACC_W'(-acc) : acc;

  assign sts.measure  = ~is_tx && item.remote_has_ours && free_slot &&
                        (item.latency_corrector != NO_LATENCY);
  assign sts.sum_last = ({1'b0, sum_idx} == CNT_W'(offset_count - CNT_W'(1)));
  assign sts.div_last = div_last;

  clse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.neg),
    .step     (cmd.div_step),
    .dividend (DIV_W'(acc_mag)),
    .divisor  (offset_count),
    .quotient (quotient),
    .last     (div_last)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= item_in;
    end
  end

  // Sync state update for one item.
  always_ff @(posedge clk) begin
    if (rst) begin
      latency_value         <= NO_LATENCY;
      round_trip_value      <= '0;
      round_trip_seen       <= 1'b0;
      peer_latency_value    <= NO_LATENCY;
      mean_offset           <= '0;
      mean_seen             <= 1'b0;
      stored_peer_timestamp <= '0;
      have_peer_timestamp   <= 1'b0;
      corrector_time        <= '0;
      corrector_pending     <= 1'b0;
      offset_count          <= '0;
      wr_ptr                <= '0;
    end else begin
      if (cmd.exec) begin
        if (!is_tx) begin
          if (free_slot) begin
            stored_peer_timestamp <= item.remote_timestamp;
            have_peer_timestamp   <= 1'b1;
          end
          if (item.peer_reported_latency != NO_LATENCY) begin
            peer_latency_value <= item.peer_reported_latency;
          end
          if (item.remote_has_ours && free_slot) begin
            corrector_time    <= item.rx_timestamp;
            corrector_pending <= 1'b1;
            if (item.latency_corrector != NO_LATENCY) begin
              round_trip_value <= rt_new;
              round_trip_seen  <= 1'b1;
              latency_value    <= lat_half[TS_W-1:0];
            end
          end
        end else if (have_peer_timestamp) begin
          corrector_pending   <= 1'b0;
          have_peer_timestamp <= 1'b0;
        end
      end
      if (cmd.offs) begin
        if (offset_count < CNT_W'(WINDOW)) begin
          offset_count <= offset_count + CNT_W'(1);
        end
        if (wr_ptr == IDX_W'(WINDOW - 1)) begin
          wr_ptr <= '0;
        end else begin
          wr_ptr <= wr_ptr + IDX_W'(1);
        end
      end
      if (cmd.fix) begin
        mean_offset <= sum_neg ? -quotient[OFF_W-1:0] : quotient[OFF_W-1:0];
        mean_seen   <= 1'b1;
      end
    end
  end

  // Ring buffer of offsets; only entries below the fill count are ever read.
  always_ff @(posedge clk) begin
    if (cmd.offs) begin
      offset_window[wr_ptr] <= new_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      time_diff <= {1'b0, item.local_time} - {1'b0, item.remote_full_timestamp};
      tx_corr   <= NO_LATENCY;
      tx_have   <= 1'b0;
      tx_ext    <= '0;
      if (is_tx && have_peer_timestamp) begin
        tx_have <= 1'b1;
        tx_ext  <= stored_peer_timestamp;
        if (corrector_pending) begin
          tx_corr <= now_ts - corrector_time;
        end
      end
    end
    if (cmd.offs) begin
      sum_idx <= '0;
      acc     <= '0;
    end else if (cmd.sum_step) begin
      sum_idx <= sum_idx + IDX_W'(1);
      acc     <= acc + {{(ACC_W-OFF_W){win_rd[OFF_W-1]}}, win_rd};
    end
    if (cmd.neg) begin
      sum_neg <= acc[ACC_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.latency               <= latency_value;
      result.round_trip            <= round_trip_value;
      result.round_trip_valid      <= round_trip_seen;
      result.mean_clock_offset     <= mean_offset;
      result.offset_valid          <= mean_seen;
      result.peer_latency          <= peer_latency_value;
      result.tx_timestamp          <= now_ts;
      result.tx_corrector_latency  <= tx_corr;
      result.tx_have_external      <= tx_have;
      result.tx_external_timestamp <= tx_ext;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/clse_ctrl.sv */
// Controller of the clock sync latency estimator: sequences one word through
// the datapath and owns the handshake flags. Depends on clse_pkg.
`default_nettype none

module clse_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output clse_pkg::clse_cmd_t      cmd,
  input  wire clse_pkg::clse_sts_t sts
);
  import clse_pkg::*;

  clse_state_t state;
  clse_state_t state_next;
  logic        rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.measure ? ST_OFFS : ST_EMIT;
      end
      ST_OFFS: begin
        cmd.offs   = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_last) begin
          state_next = ST_NEG;
        end
      end
      ST_NEG: begin
        cmd.neg    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd.fix    = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

endmodule

`default_nettype wire

/* sim/clock_sync_latency_estimator_top_tb.sv */
// Self-checking testbench for the clock sync latency estimator top level.
// Drives sync and transmit words and checks each report against a predictor.
// Depends on clse_pkg, clse_req_if / clse_rsp_if and clock_sync_latency_estimator_top.
`timescale 1ns / 1ps

module clock_sync_latency_estimator_top_tb;
  import clse_pkg::*;

  // Longer than the longest result latency, so this covers any word in flight.
  localparam int DRAIN_CYCLES  = 64;
  // Length of the deliberate receiver hold-off in the backpressure test.
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_WORDS  = 1300;
  localparam int NOISE_WORDS   = 250;

  logic clk;
  logic rst;

  clse_req_if req ();
  clse_rsp_if rsp ();

  clock_sync_latency_estimator_top dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Predictor state. It mirrors the block's sync state and is updated once per
  // accepted word, in acceptance order.
  // ---------------------------------------------------------------------------
  logic [OFF_W-1:0] offset_win [WINDOW];
  int               win_count      = 0;
  logic [TS_W-1:0]  lat_q          = NO_LATENCY;
  logic [TS_W-1:0]  rtt_q          = '0;
  logic             rtt_seen       = 1'b0;
  logic [TS_W-1:0]  peer_lat_q     = NO_LATENCY;
  logic [OFF_W-1:0] mean_q         = '0;
  logic             mean_seen      = 1'b0;
  logic [TS_W-1:0]  stored_ts      = '0;
  logic             have_ts        = 1'b0;
  logic [TS_W-1:0]  corr_time      = '0;
  logic             corr_pending   = 1'b0;

  // Reports predicted for accepted words, oldest first.
  clse_result_t sync_reports [$];

  int  mismatch_count  = 0;
  int  report_index    = 0;
  int  words_sent      = 0;
  // When set, neither side inserts idle cycles.
  bit  burst_mode      = 1'b0;
  // The stimulus asks for a receiver hold-off by bumping this count.
  int  holds_requested = 0;

  // Stimulus-side view of the local clock and of the peer's skew from it.
  logic [TIME_W-1:0] clk_now  = '0;
  logic [OFF_W-1:0]  peer_skew = '0;
  logic [TS_W-1:0]   last_tx_ts = '0;

  initial begin
    for (int i = 0; i < WINDOW; i++) offset_win[i] = '0;
  end

  // Computes the report of one word and advances the predictor state.
  function automatic clse_result_t predict_sync_report(input clse_item_t w);
    clse_result_t     r;
    logic             free_slot;
    logic [TS_W-1:0]  now_ts;
    int               rtt_int;
    int               corr_int;
    int               half_ms;
    logic [OFF_W-1:0] offset_ms;
    logic signed [71:0] acc;
    logic signed [71:0] n_div;
    logic signed [71:0] quo;
    now_ts = w.local_time[TS_W-1:0];
    r.tx_timestamp          = now_ts;
    r.tx_corrector_latency  = NO_LATENCY;
    r.tx_have_external      = 1'b0;
    r.tx_external_timestamp = '0;
    if (w.opcode == OP_RECEIVE) begin
      // A pending corrector freezes the stored peer timestamp and blocks any echo.
      free_slot = !corr_pending;
      if (free_slot) begin
        stored_ts = w.remote_timestamp;
        have_ts   = 1'b1;
      end
      if (w.peer_reported_latency != NO_LATENCY) peer_lat_q = w.peer_reported_latency;
      if (w.remote_has_ours && free_slot) begin
        corr_time    = w.rx_timestamp;
        corr_pending = 1'b1;
        if (w.latency_corrector != NO_LATENCY) begin
          rtt_q    = w.rx_timestamp - w.echoed_timestamp;
          rtt_seen = 1'b1;
          rtt_int  = int'(rtt_q);
          corr_int = int'(w.latency_corrector);
          // Signed halving truncates toward zero before the 16-bit wrap.
          half_ms  = (rtt_int - corr_int) / 2;
          lat_q    = half_ms[TS_W-1:0];
          offset_ms = {1'b0, w.local_time} - {1'b0, w.remote_full_timestamp}
                      + {{(OFF_W-TS_W){1'b0}}, lat_q};
          if (win_count >= WINDOW) begin
            for (int i = 0; i + 1 < WINDOW; i++) offset_win[i] = offset_win[i+1];
            offset_win[WINDOW-1] = offset_ms;
          end else begin
            offset_win[win_count] = offset_ms;
            win_count++;
          end
          // Exact signed sum, then division truncating toward zero.
          acc = '0;
          for (int i = 0; i < win_count; i++) acc = acc + 72'($signed(offset_win[i]));
          n_div     = 72'(win_count);
          quo       = acc / n_div;
          mean_q    = quo[OFF_W-1:0];
          mean_seen = 1'b1;
        end
      end
    end else if (have_ts) begin
      r.tx_have_external      = 1'b1;
      r.tx_external_timestamp = stored_ts;
      if (corr_pending) begin
        r.tx_corrector_latency = now_ts - corr_time;
        corr_pending = 1'b0;
      end
      have_ts = 1'b0;
    end
    r.latency          = lat_q;
    r.round_trip       = rtt_q;
    r.round_trip_valid = rtt_seen;
    r.mean_clock_offset = mean_q;
    r.offset_valid     = mean_seen;
    r.peer_latency     = peer_lat_q;
    return r;
  endfunction

  function automatic void check_field(input string fname, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("report %0d: %s expected %h, got %h", report_index, fname, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor. Predicts on every accepted request word and checks every accepted
  // report against the oldest prediction. Both sides are sampled at the edge,
  // before any of this edge's updates land.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    clse_item_t   w_in;
    clse_result_t want;
    if (!rst) begin
      if (req.valid && req.ready) begin
        w_in.opcode                = req.opcode;
        w_in.local_time            = req.local_time;
        w_in.rx_timestamp          = req.rx_timestamp;
        w_in.remote_timestamp      = req.remote_timestamp;
        w_in.latency_corrector     = req.latency_corrector;
        w_in.peer_reported_latency = req.peer_reported_latency;
        w_in.remote_full_timestamp = req.remote_full_timestamp;
        w_in.remote_has_ours       = req.remote_has_ours;
        w_in.echoed_timestamp      = req.echoed_timestamp;
        sync_reports.push_back(predict_sync_report(w_in));
      end
      if (rsp.valid && rsp.ready) begin
        if (sync_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("report %0d arrived with no word outstanding", report_index);
        end else begin
          want = sync_reports.pop_front();
          check_field("latency", 64'(want.latency), 64'(rsp.latency));
          check_field("round_trip", 64'(want.round_trip), 64'(rsp.round_trip));
          check_field("round_trip_valid", 64'(want.round_trip_valid),
                      64'(rsp.round_trip_valid));
          check_field("mean_clock_offset", want.mean_clock_offset, rsp.mean_clock_offset);
          check_field("offset_valid", 64'(want.offset_valid), 64'(rsp.offset_valid));
          check_field("peer_latency", 64'(want.peer_latency), 64'(rsp.peer_latency));
          check_field("tx_timestamp", 64'(want.tx_timestamp), 64'(rsp.tx_timestamp));
          check_field("tx_corrector_latency", 64'(want.tx_corrector_latency),
                      64'(rsp.tx_corrector_latency));
          check_field("tx_have_external", 64'(want.tx_have_external),
                      64'(rsp.tx_have_external));
          check_field("tx_external_timestamp", 64'(want.tx_external_timestamp),
                      64'(rsp.tx_external_timestamp));
        end
        report_index++;
      end
    end
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver. Random stalls, plus a counted hold-off whenever the stimulus asks
  // for one, so the block backs up and stalls its request side.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    int hold_left;
    int holds_served;
    stall_left   = 0;
    hold_left    = 0;
    holds_served = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_served != holds_requested) begin
        hold_left = HOLD_CYCLES;
        holds_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        stall_left = idle_gap();
      end
    end
  end

  // Sends one word and returns at the edge that takes it, plus an idle gap.
  // With no gap, valid stays high for the next word.
  task automatic send_word(input clse_item_t w);
    int gap;
    req.valid                 <= 1'b1;
    req.opcode                <= w.opcode;
    req.local_time            <= w.local_time;
    req.rx_timestamp          <= w.rx_timestamp;
    req.remote_timestamp      <= w.remote_timestamp;
    req.latency_corrector     <= w.latency_corrector;
    req.peer_reported_latency <= w.peer_reported_latency;
    req.remote_full_timestamp <= w.remote_full_timestamp;
    req.remote_has_ours       <= w.remote_has_ours;
    req.echoed_timestamp      <= w.echoed_timestamp;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    words_sent++;
    gap = idle_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[TIME_W-1:0];
  endfunction

  // 16-bit value biased toward both ends of the range.
  function automatic logic [TS_W-1:0] rand_ts();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return TS_W'($urandom_range(0, 65535));
  endfunction

  function automatic clse_item_t blank_word();
    clse_item_t w;
    w = '0;
    w.latency_corrector     = NO_LATENCY;
    w.peer_reported_latency = NO_LATENCY;
    return w;
  endfunction

  // Moves the local clock forward; now and then it jumps anywhere in its range.
  task automatic advance_clock();
    if ($urandom_range(0, 49) == 0) clk_now = rand_time();
    else clk_now = clk_now + TIME_W'($urandom_range(0, 3000));
  endtask

  task automatic send_transmit();
    clse_item_t w;
    w = blank_word();
    advance_clock();
    w.opcode     = OP_TRANSMIT;
    w.local_time = clk_now;
    last_tx_ts   = clk_now[TS_W-1:0];
    send_word(w);
  endtask

  // A peer sync packet. With an echo it normally returns our last timestamp after
  // a plausible round trip, with a hold time inside that round trip.
  task automatic send_peer_packet(input bit with_echo);
    clse_item_t w;
    int         rtt;
    int         r;
    logic [TIME_W-1:0] peer_clock;
    w = blank_word();
    advance_clock();
    peer_clock = clk_now - peer_skew[TIME_W-1:0];
    w.opcode                = OP_RECEIVE;
    w.local_time            = clk_now;
    w.remote_full_timestamp = peer_clock;
    w.remote_timestamp      = ($urandom_range(0, 9) == 0) ? rand_ts()
                                                           : peer_clock[TS_W-1:0];
    w.peer_reported_latency = ($urandom_range(0, 2) == 0) ? NO_LATENCY : rand_ts();
    w.remote_has_ours       = with_echo;
    rtt = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3000) : $urandom_range(0, 65535);
    w.echoed_timestamp = ($urandom_range(0, 19) == 0) ? rand_ts() : last_tx_ts;
    w.rx_timestamp     = w.echoed_timestamp + rtt[TS_W-1:0];
    r = $urandom_range(0, 99);
    if (r < 70) w.latency_corrector = TS_W'($urandom_range(0, rtt));
    else if (r < 80) w.latency_corrector = NO_LATENCY;
    else w.latency_corrector = TS_W'($urandom_range(0, 65534));
    send_word(w);
  endtask

  // One exchange: we transmit, and the peer usually answers with an echo.
  task automatic run_exchange();
    int r;
    send_transmit();
    r = $urandom_range(0, 99);
    if (r < 80) send_peer_packet(1'b1);
    else if (r < 90) send_peer_packet(1'b0);
  endtask

  task automatic pick_peer_skew();
    logic [63:0] v;
    if ($urandom_range(0, 1) == 0) begin
      v = {$urandom, $urandom};
      peer_skew = v;
    end else begin
      peer_skew = OFF_W'($urandom_range(0, 1 << 21));
      peer_skew = peer_skew - (64'd1 << 20);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // A transmit straight after reset has no peer timestamp to echo.
  task automatic test_reset_transmit();
    clse_item_t w;
    w = blank_word();
    w.opcode     = OP_TRANSMIT;
    w.local_time = '1;
    send_word(w);
  endtask

  // Latching of the peer timestamp, a corrector without a hold time, an echo
  // ignored while a corrector is pending, and a corrector latency that wraps.
  task automatic test_echo_rules();
    clse_item_t w;
    w = blank_word();
    w.opcode                = OP_RECEIVE;
    w.remote_timestamp      = '1;
    w.remote_full_timestamp = '1;
    send_word(w);

    // Stored peer timestamp but no corrector pending.
    w = blank_word();
    w.opcode     = OP_TRANSMIT;
    w.local_time = 63'h1234;
    send_word(w);

    // Echo with no hold time: the corrector latches, nothing is measured.
    w = blank_word();
    w.opcode                = OP_RECEIVE;
    w.local_time            = 63'h2000;
    w.remote_timestamp      = 16'h00aa;
    w.remote_has_ours       = 1'b1;
    w.rx_timestamp          = 16'h0010;
    w.echoed_timestamp      = 16'h1234;
    w.peer_reported_latency = 16'h0000;
    send_word(w);

    // Echo while the corrector is pending: ignored, and the stored timestamp holds.
    w = blank_word();
    w.opcode                = OP_RECEIVE;
    w.remote_timestamp      = 16'h5555;
    w.remote_has_ours       = 1'b1;
    w.rx_timestamp          = 16'd100;
    w.latency_corrector     = 16'd5;
    w.peer_reported_latency = 16'hfffe;
    send_word(w);

    // Local timestamp below the corrector time, so the latency wraps.
    w = blank_word();
    w.opcode     = OP_TRANSMIT;
    w.local_time = 63'h5;
    send_word(w);
  endtask

  // Measurements at the extremes: a wrapped round trip with a hold time larger
  // than it (negative latency), then the largest round trip with no hold time.
  task automatic test_measure_extremes();
    clse_item_t w;
    w = blank_word();
    w.opcode                = OP_RECEIVE;
    w.local_time            = '0;
    w.remote_full_timestamp = '1;
    w.remote_has_ours       = 1'b1;
    w.echoed_timestamp      = 16'hfff0;
    w.rx_timestamp          = 16'h0008;
    w.latency_corrector     = 16'hfffe;
    send_word(w);

    w = blank_word();
    w.opcode     = OP_TRANSMIT;
    w.local_time = '1;
    send_word(w);

    w = blank_word();
    w.opcode                = OP_RECEIVE;
    w.local_time            = '1;
    w.remote_full_timestamp = '0;
    w.remote_has_ours       = 1'b1;
    w.echoed_timestamp      = 16'h0000;
    w.rx_timestamp          = 16'hffff;
    w.latency_corrector     = 16'h0000;
    w.peer_reported_latency = 16'hffff;
    send_word(w);
  endtask

  // Enough measurements to fill the offset window and push the oldest out.
  task automatic test_window_fill();
    clk_now   = 63'h7fff_ffff_ffff_0000;
    peer_skew = 64'hffff_ffff_ffff_ff00;
    for (int i = 0; i < 8; i++) begin
      send_transmit();
      send_peer_packet(1'b1);
    end
  endtask

  // Mostly well-formed exchanges with random content, in blocks that each pick
  // random idling or, now and then, back-to-back traffic.
  task automatic test_random_exchanges();
    int stop_at;
    int rounds;
    stop_at = words_sent + RANDOM_WORDS;
    rounds  = 0;
    clk_now = rand_time();
    while (words_sent < stop_at) begin
      if (rounds % 40 == 0) begin
        burst_mode = ($urandom_range(0, 3) == 0);
        pick_peer_skew();
      end
      run_exchange();
      rounds++;
    end
    burst_mode = 1'b0;
  endtask

  // Fully random words: any opcode and any field values, broken sequences included.
  task automatic test_random_noise();
    clse_item_t w;
    for (int i = 0; i < NOISE_WORDS; i++) begin
      w.opcode                = 1'($urandom_range(0, 1));
      w.local_time            = rand_time();
      w.rx_timestamp          = rand_ts();
      w.remote_timestamp      = rand_ts();
      w.latency_corrector     = rand_ts();
      w.peer_reported_latency = rand_ts();
      w.remote_full_timestamp = rand_time();
      w.remote_has_ours       = 1'($urandom_range(0, 1));
      w.echoed_timestamp      = rand_ts();
      send_word(w);
    end
  endtask

  // The receiver holds off for a long stretch while words keep coming back to
  // back, so the block fills and must stall its request side.
  task automatic test_backpressure();
    burst_mode = 1'b1;
    holds_requested++;
    for (int i = 0; i < 12; i++) run_exchange();
    burst_mode = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                       <= 1'b1;
    req.valid                 <= 1'b0;
    req.opcode                <= OP_RECEIVE;
    req.local_time            <= '0;
    req.rx_timestamp          <= '0;
    req.remote_timestamp      <= '0;
    req.latency_corrector     <= '0;
    req.peer_reported_latency <= '0;
    req.remote_full_timestamp <= '0;
    req.remote_has_ours       <= 1'b0;
    req.echoed_timestamp      <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_transmit();
    test_echo_rules();
    test_measure_extremes();
    test_window_fill();
    test_random_exchanges();
    test_backpressure();
    test_random_noise();

    req.valid <= 1'b0;
    while (sync_reports.size() != 0) @(posedge clk);
    // Any stray report would show up within the longest latency.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && sync_reports.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of this stimulus.
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* clock_sync_latency_estimator_top.f */
hw/rtl/clse_pkg.sv
hw/rtl/clse_if.sv
hw/rtl/clse_div.sv
hw/rtl/clse_dp.sv
hw/rtl/clse_ctrl.sv
hw/rtl/clock_sync_latency_estimator_top.sv
sim/clock_sync_latency_estimator_top_tb.sv
